// ----- design/ppt_pkg.sv -----
// Shared types and widths for the projective point transform datapath.
package ppt_pkg;

  localparam int REM_W = 91;  // magnitude of numerator, scale 2^40
  localparam int DVS_W = 65;  // |denominator| * 256
  localparam int QUO_W = 24;  // quotient bits formed by the cell chain

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             sat;
  } div_t;

endpackage

// ----- design/ppt_cell.sv -----
// One restoring division cell: decides one quotient bit and passes on.
module ppt_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  ppt_pkg::div_t din,
  output ppt_pkg::div_t dout
);

  logic [ppt_pkg::REM_W-1:0] sh;
  logic                      take;
  ppt_pkg::div_t             dout_next;

  assign sh   = ppt_pkg::REM_W'(din.dvs) << BIT;
  assign take = din.rem >= sh;

  always_comb begin
    dout_next          = din;
    dout_next.rem      = take ? din.rem - sh : din.rem;
    dout_next.quo[BIT] = take;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

// ----- design/projective_point_transform_top.sv -----
// Top level of the weighted projective point transform.
// Pipeline: stage A loads on the accept edge, then come stages B and C,
// 24 division cells and 1 output register.
// Throughput: one item per cycle; the whole pipe advances whenever the output
// register is empty or being taken. Input waits in the cycle after a cfg write.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
module projective_point_transform_top #(
  parameter int BASE_WEIGHT = 400
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // in_x [23:0], in_y [47:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_x [23:0], out_y [47:24]
  output logic [1:0]  m_tuser,   // zero_denominator [0], saturated [1]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NCELL = ppt_pkg::QUO_W;
  localparam logic [15:0] BW16 = BASE_WEIGHT[15:0];
  localparam logic signed [57:0] DEN0 = 58'(BW16) <<< 24;

  typedef enum logic [2:0] {
    R_ORIGIN_X, R_ORIGIN_Y, R_XAXIS_DX, R_XAXIS_DY,
    R_YAXIS_DX, R_YAXIS_DY, R_WEIGHT_X, R_WEIGHT_Y
  } reg_idx_t;

  // configuration registers
  logic signed [31:0] origin_x, origin_y, xaxis_dx, xaxis_dy;
  logic signed [31:0] yaxis_dx, yaxis_dy, weight_x, weight_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      xaxis_dx <= 32'sd39321600;
      xaxis_dy <= '0;
      yaxis_dx <= '0;
      yaxis_dy <= 32'sd39321600;
      weight_x <= 32'sd65536;
      weight_y <= 32'sd65536;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        R_ORIGIN_X: origin_x <= cfg_data;
        R_ORIGIN_Y: origin_y <= cfg_data;
        R_XAXIS_DX: xaxis_dx <= cfg_data;
        R_XAXIS_DY: xaxis_dy <= cfg_data;
        R_YAXIS_DX: yaxis_dx <= cfg_data;
        R_YAXIS_DY: yaxis_dy <= cfg_data;
        R_WEIGHT_X: weight_x <= cfg_data;
        R_WEIGHT_Y: weight_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient products, refreshed every cycle from the registers
  logic signed [63:0] p_xx, p_yx, p_xy, p_yy;
  logic signed [48:0] p_ox, p_oy;

  always_ff @(posedge clk) begin
    p_xx <= xaxis_dx * weight_x;
    p_yx <= yaxis_dx * weight_y;
    p_xy <= xaxis_dy * weight_x;
    p_yy <= yaxis_dy * weight_y;
    p_ox <= origin_x * $signed({1'b0, BW16});
    p_oy <= origin_y * $signed({1'b0, BW16});
  end

  // products update in the cycle after a register write; hold the input meanwhile
  logic cfg_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hold <= 1'b0;
    end else begin
      cfg_hold <= cfg_we;
    end
  end

  // pipe control: one enable for every stage
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !cfg_hold;

  logic signed [23:0] xs, ys;
  assign xs = $signed(s_tdata[23:0]);
  assign ys = $signed(s_tdata[47:24]);

  // stage A: partial products, 64-bit coefficient split in halves
  logic               va;
  logic signed [56:0] a_lo [4];
  logic signed [55:0] a_hi [4];
  logic signed [55:0] a_wx, a_wy;
  logic signed [48:0] a_ox, a_oy;

  always_ff @(posedge clk) begin
    if (en) begin
      a_lo[0] <= $signed({1'b0, p_xx[31:0]}) * xs;
      a_hi[0] <= $signed(p_xx[63:32]) * xs;
      a_lo[1] <= $signed({1'b0, p_yx[31:0]}) * ys;
      a_hi[1] <= $signed(p_yx[63:32]) * ys;
      a_lo[2] <= $signed({1'b0, p_xy[31:0]}) * xs;
      a_hi[2] <= $signed(p_xy[63:32]) * xs;
      a_lo[3] <= $signed({1'b0, p_yy[31:0]}) * ys;
      a_hi[3] <= $signed(p_yy[63:32]) * ys;
      a_wx    <= weight_x * xs;
      a_wy    <= weight_y * ys;
      a_ox    <= p_ox;
      a_oy    <= p_oy;
    end
  end

  // stage B: numerator (scale 2^40) and denominator (scale 2^24)
  logic signed [91:0] t [4];
  logic signed [91:0] b_numx, b_numy;
  logic signed [57:0] b_den;
  logic               vb;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i] = (92'(a_hi[i]) <<< 32) + 92'(a_lo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_numx <= (92'(a_ox) <<< 24) + t[0] + t[1];
      b_numy <= (92'(a_oy) <<< 24) + t[2] + t[3];
      b_den  <= DEN0 + 58'(a_wx) + 58'(a_wy);
    end
  end

  // stage C: magnitudes, signs, out-of-range precheck
  logic [56:0]               den_mag;
  logic [ppt_pkg::DVS_W-1:0] dvs;
  logic [91:0]               dvs_top;
  ppt_pkg::div_t             cx_next, cy_next;
  ppt_pkg::div_t             chx [NCELL+1];
  ppt_pkg::div_t             chy [NCELL+1];
  logic                      vc;

  always_comb begin
    den_mag = b_den[57] ? 57'(-b_den) : 57'(b_den);
    dvs     = {den_mag, 8'b0};
    dvs_top = 92'(dvs) << 24;
    cx_next.rem = b_numx[91] ? ppt_pkg::REM_W'(-b_numx) : ppt_pkg::REM_W'(b_numx);
    cx_next.dvs = dvs;
    cx_next.quo = '0;
    cx_next.neg = b_numx[91] ^ b_den[57];
    cx_next.sat = 92'(cx_next.rem) >= dvs_top;
    cy_next.rem = b_numy[91] ? ppt_pkg::REM_W'(-b_numy) : ppt_pkg::REM_W'(b_numy);
    cy_next.dvs = dvs;
    cy_next.quo = '0;
    cy_next.neg = b_numy[91] ^ b_den[57];
    cy_next.sat = 92'(cy_next.rem) >= dvs_top;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chx[0] <= cx_next;
      chy[0] <= cy_next;
    end
  end

  // division chain: cell k settles quotient bit NCELL-1-k
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ppt_cell #(.BIT(NCELL - 1 - k)) u_cx (
      .clk (clk), .en (en), .din (chx[k]), .dout (chx[k+1])
    );
    ppt_cell #(.BIT(NCELL - 1 - k)) u_cy (
      .clk (clk), .en (en), .din (chy[k]), .dout (chy[k+1])
    );
  end

  // valid and zero-denominator flags ride alongside the chain;
  // vch[j] lines up with chx[j+1], zch[j] with chx[j]
  logic [NCELL-1:0] vch;
  logic [NCELL:0]   zch;
  logic             zb;

  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      vch      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      va       <= s_tvalid && !cfg_hold;
      vb       <= va;
      vc       <= vb;
      vch      <= {vch[NCELL-2:0], vc};
      m_tvalid <= vch[NCELL-1];
    end
  end

  assign zb = b_den == '0;

  always_ff @(posedge clk) begin
    if (en) begin
      zch <= {zch[NCELL-1:0], zb};
    end
  end

  // clip quotient to Q16.8 range and apply sign
  function automatic logic [24:0] finish(ppt_pkg::div_t d);
    logic [24:0] lim;
    logic [24:0] mag;
    logic        s;
    lim = d.neg ? 25'd8388608 : 25'd8388607;
    mag = {1'b0, d.quo};
    s   = d.sat || (mag > lim);
    if (s) mag = lim;
    if (d.neg) mag = -mag;
    return {s, mag[23:0]};
  endfunction

  logic [24:0] fx, fy;
  logic        zo;
  assign fx = finish(chx[NCELL]);
  assign fy = finish(chy[NCELL]);
  assign zo = zch[NCELL];

  always_ff @(posedge clk) begin
    if (en) begin
      if (zo) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {fy[23:0], fx[23:0]};
        m_tuser <= {fx[24] | fy[24], 1'b0};
      end
    end
  end

endmodule

// ----- test/ppt_test_pkg.sv -----
// Coefficient register map and build constants shared by the transform testbench.
`timescale 1ns / 1ps
package ppt_test_pkg;

  localparam int BASE_WEIGHT = 400;
  localparam int NUM_COEFS   = 8;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_XAXIS_DX = 3'd2,
    REG_XAXIS_DY = 3'd3,
    REG_YAXIS_DX = 3'd4,
    REG_YAXIS_DY = 3'd5,
    REG_WEIGHT_X = 3'd6,
    REG_WEIGHT_Y = 3'd7
  } coef_reg_e;

endpackage

// ----- test/ppt_point_checker.sv -----
// Checker: predicts each transformed point and compares it with the result stream.
`timescale 1ns / 1ps
module ppt_point_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          points_seen,
  output int          zero_den_seen,
  output int          sat_seen
);

  typedef struct packed {
    logic [23:0] out_x;
    logic [23:0] out_y;
    logic        zero_den;
    logic        sat;
  } point_result_t;

  logic [31:0] coef [ppt_test_pkg::NUM_COEFS];
  point_result_t expected_points [$];

  // quotient in Q16.8: numerator at 2^40 over denominator at 2^24, truncated
  function automatic logic [23:0] scaled_quotient(input logic signed [127:0] num,
                                                  input logic signed [127:0] den,
                                                  inout logic sat);
    logic        neg;
    logic [127:0] mag_n, mag_d, q, limit;
    neg   = (num < 0) != (den < 0);
    mag_n = (num < 0) ? -num : num;
    mag_d = ((den < 0) ? -den : den) * 128'd256;
    q     = mag_n / mag_d;
    limit = neg ? 128'd8388608 : 128'd8388607;
    if (q > limit) begin
      q   = limit;
      sat = 1'b1;
    end
    return neg ? 24'(-q) : 24'(q);
  endfunction

  function automatic point_result_t project_point(input logic [23:0] px, input logic [23:0] py);
    logic signed [127:0] x, y, wx, wy, den, nx, ny, base;
    point_result_t r;
    x    = $signed(px);
    y    = $signed(py);
    wx   = $signed(coef[ppt_test_pkg::REG_WEIGHT_X]);
    wy   = $signed(coef[ppt_test_pkg::REG_WEIGHT_Y]);
    base = 128'sd16777216 * ppt_test_pkg::BASE_WEIGHT;
    den  = base + wx * x + wy * y;
    r    = '0;
    if (den == 0) begin
      r.zero_den = 1'b1;
      return r;
    end
    nx = $signed(coef[ppt_test_pkg::REG_ORIGIN_X]) * base
       + $signed(coef[ppt_test_pkg::REG_XAXIS_DX]) * wx * x
       + $signed(coef[ppt_test_pkg::REG_YAXIS_DX]) * wy * y;
    ny = $signed(coef[ppt_test_pkg::REG_ORIGIN_Y]) * base
       + $signed(coef[ppt_test_pkg::REG_XAXIS_DY]) * wx * x
       + $signed(coef[ppt_test_pkg::REG_YAXIS_DY]) * wy * y;
    r.out_x = scaled_quotient(nx, den, r.sat);
    r.out_y = scaled_quotient(ny, den, r.sat);
    return r;
  endfunction

  assign pending = expected_points.size();

  always @(posedge clk) begin
    point_result_t got, want;
    if (rst) begin
      coef[ppt_test_pkg::REG_ORIGIN_X] <= 32'd0;
      coef[ppt_test_pkg::REG_ORIGIN_Y] <= 32'd0;
      coef[ppt_test_pkg::REG_XAXIS_DX] <= 32'd39321600;
      coef[ppt_test_pkg::REG_XAXIS_DY] <= 32'd0;
      coef[ppt_test_pkg::REG_YAXIS_DX] <= 32'd0;
      coef[ppt_test_pkg::REG_YAXIS_DY] <= 32'd39321600;
      coef[ppt_test_pkg::REG_WEIGHT_X] <= 32'd65536;
      coef[ppt_test_pkg::REG_WEIGHT_Y] <= 32'd65536;
      expected_points.delete();
      fail_count    <= 0;
      points_seen   <= 0;
      zero_den_seen <= 0;
      sat_seen      <= 0;
    end else begin
      if (cfg_we)
        coef[cfg_index] <= cfg_data;
      if (s_tvalid && s_tready)
        expected_points.push_back(project_point(s_tdata[23:0], s_tdata[47:24]));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[23:0], m_tdata[47:24], m_tuser[0], m_tuser[1]};
        points_seen <= points_seen + 1;
        if (m_tuser[0]) zero_den_seen <= zero_den_seen + 1;
        if (m_tuser[1]) sat_seen <= sat_seen + 1;
        if (expected_points.size() == 0) begin
          fail_count <= fail_count + 1;
          $display("%0t: unexpected result x=%h y=%h user=%b", $time,
                   got.out_x, got.out_y, m_tuser);
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            $display("%0t: mismatch exp x=%h y=%h zd=%b sat=%b  act x=%h y=%h zd=%b sat=%b",
                     $time, want.out_x, want.out_y, want.zero_den, want.sat,
                     got.out_x, got.out_y, got.zero_den, got.sat);
          end
        end
      end
    end
  end

endmodule

// ----- test/projective_point_transform_top_test.sv -----
// Top of the projective point transform testbench: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module projective_point_transform_top_test;

  localparam int PHASES        = 8;
  localparam int POINTS_PER_PH = 200;
  localparam int PIPE_LATENCY  = 28;
  localparam int STALL_LIMIT   = 5000;

  logic        clk;
  logic        rst;
  logic        s_tvalid, s_tready;
  logic [47:0] s_tdata;  // in_x [23:0], in_y [47:24]
  logic        m_tvalid, m_tready;
  logic [47:0] m_tdata;  // out_x [23:0], out_y [47:24]
  logic [1:0]  m_tuser;  // zero_denominator [0], saturated [1]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  int  fail_count, pending, points_seen, zero_den_seen, sat_seen;
  int  coef_sets;
  int  quiet_cycles;
  bit  idle_en;
  // mirror of what was written, for picking points
  logic [31:0] coef_now [ppt_test_pkg::NUM_COEFS];

  projective_point_transform_top #(.BASE_WEIGHT(ppt_test_pkg::BASE_WEIGHT)) u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  ppt_point_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending, .points_seen, .zero_den_seen, .sat_seen
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no traffic for %0d cycles", $time, STALL_LIMIT);
        $display("** projective_point_transform_top: FAILED **");
        $finish;
      end
    end
  end

  // downstream stalls in random bursts
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_en && !rst && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        m_tready = 1'b1;
      end
    end
  end

  // called at a falling edge; returns at a falling edge after the item is taken
  task automatic send_point(input logic [23:0] px, input logic [23:0] py);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {py, px};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic write_coef(input ppt_test_pkg::coef_reg_e idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    coef_now[idx] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // pipe must be empty before coefficients change
  task automatic drain_pipe();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));  // +-256.0
      2: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));  // +-16.0
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 4)) - 2) << 16; // small integer
    endcase
  endfunction

  // one coefficient set per phase; extremes and special weights in fixed phases
  task automatic load_phase(input int ph);
    logic [31:0] v;
    for (int i = 0; i < ppt_test_pkg::NUM_COEFS; i++) begin
      case (ph)
        1: v = 32'h8000_0000;
        2: v = 32'h7fff_ffff;
        4: v = (i == ppt_test_pkg::REG_WEIGHT_X) ?
                 32'($signed($urandom_range(0, 4)) - 2) << 16 :
               (i == ppt_test_pkg::REG_WEIGHT_Y) ? 32'h0001_0000 : pick_coef();
        5: v = (i >= ppt_test_pkg::REG_WEIGHT_X) ? 32'd0 : pick_coef();
        7: v = (i == ppt_test_pkg::REG_WEIGHT_Y) ? 32'hffff_0000 : pick_coef();
        default: v = pick_coef();
      endcase
      write_coef(ppt_test_pkg::coef_reg_e'(i), v);
    end
    coef_sets++;
  endtask

  // random point; sometimes placed on the zero-denominator line when weights allow
  task automatic random_point(output logic [23:0] px, output logic [23:0] py);
    longint kx, ky, ty;
    case ($urandom_range(0, 2))
      0: begin px = $urandom; py = $urandom; end
      1: begin px = 24'($signed($urandom_range(0, 8192)) - 4096);
               py = 24'($signed($urandom_range(0, 8192)) - 4096); end
      default: begin px = 24'($signed($urandom_range(0, 400000)) - 200000);
                     py = 24'($signed($urandom_range(0, 400000)) - 200000); end
    endcase
    if (coef_now[ppt_test_pkg::REG_WEIGHT_X][15:0] == 16'd0 && $urandom_range(0, 5) == 0 &&
        (coef_now[ppt_test_pkg::REG_WEIGHT_Y] == 32'h0001_0000 ||
         coef_now[ppt_test_pkg::REG_WEIGHT_Y] == 32'hffff_0000)) begin
      kx = $signed(coef_now[ppt_test_pkg::REG_WEIGHT_X]) >>> 16;
      ky = $signed(coef_now[ppt_test_pkg::REG_WEIGHT_Y]) >>> 16;
      ty = -(longint'(ppt_test_pkg::BASE_WEIGHT) * 256 + kx * $signed(px)) * ky;
      if (ty >= -8388608 && ty <= 8388607)
        py = 24'(ty);
    end
  endtask

  initial begin
    logic [23:0] px, py;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_en   = 1'b1;
    coef_sets = 1;
    coef_now  = '{32'd0, 32'd0, 32'd39321600, 32'd0, 32'd0, 32'd39321600,
                  32'd65536, 32'd65536};
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed, reset coefficients: extremes, zero denominator at x+y = -400.0,
    // points just off it (huge quotients saturate), signs and truncation
    send_point(24'd0, 24'd0);
    send_point(24'h7fffff, 24'h7fffff);
    send_point(24'h800000, 24'h800000);
    send_point(24'h7fffff, 24'h800000);
    send_point(24'h800000, 24'h7fffff);
    send_point(-24'd102400, 24'd0);
    send_point(24'd0, -24'd102400);
    send_point(-24'd51200, -24'd51200);
    send_point(-24'd102401, 24'd0);
    send_point(-24'd102399, 24'd0);
    send_point(24'h800000, 24'h7fffff - 24'd102400 + 24'd1);
    send_point(24'd1, -24'd1);
    send_point(24'hffffff, 24'hffffff);
    send_point(24'd256, 24'd256);
    send_point(24'd3, 24'd0);
    send_point(24'h555555, 24'haaaaaa);
    send_point(24'haaaaaa, 24'h555555);
    send_point(-24'd200000, 24'd97600);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain_pipe();
        load_phase(ph);
      end
      idle_en = (ph != PHASES - 1);  // last phase runs at full rate
      for (int n = 0; n < POINTS_PER_PH; n++) begin
        random_point(px, py);
        send_point(px, py);
      end
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 8) @(negedge clk);

    $display("%0d points checked over %0d coefficient sets", points_seen, coef_sets);
    $display("%0d zero-denominator and %0d saturated results seen", zero_den_seen, sat_seen);
    if (fail_count == 0 && pending == 0)
      $display("** projective_point_transform_top: PASSED **");
    else
      $display("** projective_point_transform_top: FAILED **");
    $finish;
  end

endmodule
